// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/rpd_pkg.sv =====
package rpd_pkg;

  // Fixed header layout.
  localparam int HEADER_BYTES = 24;
  localparam int FIXED_BYTES  = 36;
  localparam int MAGIC_BYTES  = 4;
  localparam int VERSION_POS  = 4;
  localparam int KIND_POS     = 5;
  localparam int ROLE_POS     = 6;
  localparam int SEQ_FIRST    = 8;
  localparam int STAMP_FIRST  = 16;
  localparam int LAST_FIELD   = 5;

  localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h47, 8'h52, 8'h4C, 8'h59};
  localparam logic [7:0] VERSION_OK = 8'd1;

  localparam logic [7:0] KIND_MIN = 8'd1;
  localparam logic [7:0] KIND_MAX = 8'd6;
  localparam logic [7:0] ROLE_MIN = 8'd1;
  localparam logic [7:0] ROLE_MAX = 8'd2;

  // Region tags carried on tuser.
  localparam logic [3:0] REGION_HEADER = 4'd0;
  localparam logic [3:0] REGION_PREFIX = 4'd1;
  localparam logic [3:0] REGION_TEXT0  = 4'd2;
  localparam logic [3:0] REGION_TAIL   = 4'd8;

  // Status codes, in priority order.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SIZE      = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_MALFORMED = 4'd3;
  localparam logic [3:0] ST_TRAILING  = 4'd4;
  localparam logic [3:0] ST_VERSION   = 4'd5;
  localparam logic [3:0] ST_KIND      = 4'd6;
  localparam logic [3:0] ST_ROLE      = 4'd7;
  localparam logic [3:0] ST_NO_ROOM   = 4'd8;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_TAIL   = 5'b10000
  } phase_t;

endpackage

// ===== rtl/relay_packet_deframer.sv =====
// Relay packet deframer. Takes one packet byte per transfer on the slave stream, with tlast on
// the final byte, and returns one transfer per byte on the master stream: the byte itself, a
// region tag on tuser (0 fixed header, 1 length prefix, 2 to 6 the five text fields, 7 payload,
// 8 MAC or anything beyond), and the running kind, role, sequence number and timestamp. On the
// last byte the status field reports the first error found, in this priority: size, magic,
// malformed, trailing, version, kind, role, empty room code; it is zero on all other bytes.
// After the last byte every parse register returns to its reset value, so the next packet may
// follow in the very next cycle. The block sustains one byte per clock unless back-pressured:
// each byte passes through a single pass of parse logic into the result register, and a new
// byte is taken whenever the result register is empty or is being drained in the same cycle.
// The byte counter saturates one past MAX_PACKET_BYTES, which keeps overlong packets flagged as
// a size error. There is no clearing pass after reset.
`include "assert_macros.svh"

module relay_packet_deframer
  import rpd_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 2048,
  parameter int MAC_BYTES        = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] in_byte
  input  logic         s_axis_tlast,  // in_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,  // [7:0] out_byte, [11:8] status, [14:12] kind_code,
                                      // [16:15] role_code, [80:17] seq_number,
                                      // [144:81] time_stamp, [151:145] zero
  output logic [3:0]   m_axis_tuser,  // [3:0] region
  output logic         m_axis_tlast   // is_last
);

  // The byte counter must hold MAX_PACKET_BYTES + 1; the tail counter MAC_BYTES + 1.
  localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 2);
  localparam int TAIL_W = $clog2(MAC_BYTES + 2);

  localparam logic [CNT_W-1:0]  CNT_SAT   = CNT_W'(MAX_PACKET_BYTES + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_PACKET_BYTES);
  localparam logic [CNT_W-1:0]  CNT_MIN   = CNT_W'(FIXED_BYTES + MAC_BYTES);
  localparam logic [CNT_W-1:0]  POS_MAGIC = CNT_W'(MAGIC_BYTES);
  localparam logic [CNT_W-1:0]  POS_VER   = CNT_W'(VERSION_POS);
  localparam logic [CNT_W-1:0]  POS_KIND  = CNT_W'(KIND_POS);
  localparam logic [CNT_W-1:0]  POS_ROLE  = CNT_W'(ROLE_POS);
  localparam logic [CNT_W-1:0]  POS_SEQ   = CNT_W'(SEQ_FIRST);
  localparam logic [CNT_W-1:0]  POS_STAMP = CNT_W'(STAMP_FIRST);
  localparam logic [CNT_W-1:0]  POS_HLAST = CNT_W'(HEADER_BYTES - 1);
  localparam logic [TAIL_W-1:0] TAIL_SAT  = TAIL_W'(MAC_BYTES + 1);
  localparam logic [TAIL_W-1:0] TAIL_GOOD = TAIL_W'(MAC_BYTES);
  localparam logic [2:0]        FIELD_END = 3'(LAST_FIELD);

  // Parse state.
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  phase_t            phase, phase_next;
  logic [15:0]       field_remaining, field_remaining_next;
  logic [7:0]        length_high, length_high_next;
  logic [2:0]        field_index, field_index_next;
  logic [TAIL_W-1:0] tail_count, tail_count_next;
  logic              magic_good, magic_good_next;
  logic [7:0]        version_held, version_held_next;
  logic [2:0]        kind_held, kind_held_next;
  logic [1:0]        role_held, role_held_next;
  logic [63:0]       seq_held, seq_held_next;
  logic [63:0]       stamp_held, stamp_held_next;
  logic              room_empty, room_empty_next;

  // Result register.
  logic [7:0]  out_byte;
  logic [3:0]  region, region_next;
  logic [3:0]  status, status_next;
  logic [2:0]  kind_code;
  logic [1:0]  role_code;
  logic [63:0] seq_number;
  logic [63:0] time_stamp;
  logic        is_last;

  logic        in_accept;
  logic [15:0] prefix_len;

  // The result register can take a new byte when it is empty or being drained right now.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign prefix_len    = {length_high, s_axis_tdata};

  always_comb begin
    byte_count_next      = byte_count;
    phase_next           = phase;
    field_remaining_next = field_remaining;
    length_high_next     = length_high;
    field_index_next     = field_index;
    tail_count_next      = tail_count;
    magic_good_next      = magic_good;
    version_held_next    = version_held;
    kind_held_next       = kind_held;
    role_held_next       = role_held;
    seq_held_next        = seq_held;
    stamp_held_next      = stamp_held;
    room_empty_next      = room_empty;
    region_next          = REGION_TAIL;
    status_next          = ST_OK;

    if (byte_count != CNT_SAT) begin
      byte_count_next = byte_count + 1'b1;
    end

    case (phase)
      PH_HEADER: begin
        region_next = REGION_HEADER;
        if (byte_count < POS_MAGIC) begin
          if (s_axis_tdata != MAGIC[byte_count[1:0]]) begin
            magic_good_next = 1'b0;
          end
        end else if (byte_count == POS_VER) begin
          version_held_next = s_axis_tdata;
        end else if (byte_count == POS_KIND) begin
          kind_held_next = (s_axis_tdata inside {[KIND_MIN:KIND_MAX]}) ? s_axis_tdata[2:0] : 3'd0;
        end else if (byte_count == POS_ROLE) begin
          role_held_next = (s_axis_tdata inside {[ROLE_MIN:ROLE_MAX]}) ? s_axis_tdata[1:0] : 2'd0;
        end else if (byte_count >= POS_SEQ && byte_count < POS_STAMP) begin
          seq_held_next = {seq_held[55:0], s_axis_tdata};
        end else if (byte_count >= POS_STAMP) begin
          stamp_held_next = {stamp_held[55:0], s_axis_tdata};
        end
        if (byte_count >= POS_HLAST) begin
          phase_next       = PH_LEN_HI;
          field_index_next = 3'd0;
        end
      end
      PH_LEN_HI: begin
        region_next      = REGION_PREFIX;
        length_high_next = s_axis_tdata;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        region_next = REGION_PREFIX;
        if (field_index == 3'd0) begin
          room_empty_next = (prefix_len == 16'd0);
        end
        if (prefix_len == 16'd0) begin
          // An empty field is skipped straight after its prefix.
          if (field_index == FIELD_END) begin
            phase_next = PH_TAIL;
          end else begin
            field_index_next = field_index + 1'b1;
            phase_next       = PH_LEN_HI;
          end
        end else begin
          field_remaining_next = prefix_len;
          phase_next           = PH_BODY;
        end
      end
      PH_BODY: begin
        region_next = REGION_TEXT0 + {1'b0, field_index};
        if (field_remaining != 16'd0) begin
          field_remaining_next = field_remaining - 1'b1;
        end
        if (field_remaining_next == 16'd0) begin
          if (field_index == FIELD_END) begin
            phase_next = PH_TAIL;
          end else begin
            field_index_next = field_index + 1'b1;
            phase_next       = PH_LEN_HI;
          end
        end
      end
      PH_TAIL: begin
        region_next = REGION_TAIL;
        if (tail_count != TAIL_SAT) begin
          tail_count_next = tail_count + 1'b1;
        end
      end
      default: begin
        region_next = REGION_TAIL;
        phase_next  = PH_HEADER;
      end
    endcase

    // The closing status looks at the state as it stands after this byte.
    if (s_axis_tlast) begin
      if (byte_count_next < CNT_MIN || byte_count_next > CNT_MAX) begin
        status_next = ST_SIZE;
      end else if (!magic_good_next) begin
        status_next = ST_MAGIC;
      end else if (phase_next != PH_TAIL) begin
        status_next = ST_MALFORMED;
      end else if (tail_count_next != TAIL_GOOD) begin
        status_next = ST_TRAILING;
      end else if (version_held_next != VERSION_OK) begin
        status_next = ST_VERSION;
      end else if (kind_held_next == 3'd0) begin
        status_next = ST_KIND;
      end else if (role_held_next == 2'd0) begin
        status_next = ST_ROLE;
      end else if (room_empty_next) begin
        status_next = ST_NO_ROOM;
      end
    end
  end

  // Parse state; the last byte of a packet returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (in_accept && s_axis_tlast)) begin
      byte_count      <= '0;
      phase           <= PH_HEADER;
      field_remaining <= '0;
      length_high     <= '0;
      field_index     <= '0;
      tail_count      <= '0;
      magic_good      <= 1'b1;
      version_held    <= '0;
      kind_held       <= '0;
      role_held       <= '0;
      seq_held        <= '0;
      stamp_held      <= '0;
      room_empty      <= 1'b0;
    end else if (in_accept) begin
      byte_count      <= byte_count_next;
      phase           <= phase_next;
      field_remaining <= field_remaining_next;
      length_high     <= length_high_next;
      field_index     <= field_index_next;
      tail_count      <= tail_count_next;
      magic_good      <= magic_good_next;
      version_held    <= version_held_next;
      kind_held       <= kind_held_next;
      role_held       <= role_held_next;
      seq_held        <= seq_held_next;
      stamp_held      <= stamp_held_next;
      room_empty      <= room_empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte   <= s_axis_tdata;
      region     <= region_next;
      status     <= status_next;
      kind_code  <= kind_held_next;
      role_code  <= role_held_next;
      seq_number <= seq_held_next;
      time_stamp <= stamp_held_next;
      is_last    <= s_axis_tlast;
    end
  end

  assign m_axis_tdata = {7'd0, time_stamp, seq_number, role_code, kind_code, status, out_byte};
  assign m_axis_tuser = region;
  assign m_axis_tlast = is_last;

  // A status other than ok only ever closes a packet.
  `ASSERT_SAME_CYCLE(a_status_on_last, m_axis_tvalid && !m_axis_tlast, status == ST_OK)
  // The last byte leaves the parser back at the start of a packet.
  `ASSERT_NEXT_CYCLE(a_restart, in_accept && s_axis_tlast,
                     phase == PH_HEADER && byte_count == '0 && magic_good)
  // The tail is only reached after the payload, the last length-prefixed field.
  `ASSERT_SAME_CYCLE(a_tail_after_payload, phase == PH_TAIL, field_index == FIELD_END)

endmodule
